// ----- design/psq_pkg.sv -----
// Package with tables, state type and widths for the pseudosquare prime test.
`timescale 1ns / 1ps
package psq_pkg;
   localparam int NumBits = 64;
   localparam int BaseTableDepth = 128;
   localparam int PsqCount = 58;
   localparam int IdxW = $clog2(BaseTableDepth);
   localparam int BitW = $clog2(NumBits);
   localparam int PsqW = $clog2(PsqCount);

   typedef enum logic [3:0] {
      ST_IDLE, ST_POW_START, ST_REDUCE, ST_SQ_START, ST_SQ, ST_ML_START, ST_ML,
      ST_NEXT_BIT, ST_CHECK
   } state_type;

   typedef enum logic [1:0] {
      PH_BASE2, PH_BASES, PH_EXT
   } phase_type;

   function automatic logic [9:0] base_prime(input logic [IdxW-1:0] i);
      logic [9:0] t [0:127];
      t = '{
         10'd2, 10'd3, 10'd5, 10'd7, 10'd11, 10'd13, 10'd17, 10'd19, 10'd23, 10'd29,
         10'd31, 10'd37, 10'd41, 10'd43, 10'd47, 10'd53, 10'd59, 10'd61, 10'd67, 10'd71,
         10'd73, 10'd79, 10'd83, 10'd89, 10'd97, 10'd101, 10'd103, 10'd107, 10'd109,
         10'd113, 10'd127, 10'd131, 10'd137, 10'd139, 10'd149, 10'd151, 10'd157, 10'd163,
         10'd167, 10'd173, 10'd179, 10'd181, 10'd191, 10'd193, 10'd197, 10'd199, 10'd211,
         10'd223, 10'd227, 10'd229, 10'd233, 10'd239, 10'd241, 10'd251, 10'd257, 10'd263,
         10'd269, 10'd271, 10'd277, 10'd281, 10'd283, 10'd293, 10'd307, 10'd311, 10'd313,
         10'd317, 10'd331, 10'd337, 10'd347, 10'd349, 10'd353, 10'd359, 10'd367, 10'd373,
         10'd379, 10'd383, 10'd389, 10'd397, 10'd401, 10'd409, 10'd419, 10'd421, 10'd431,
         10'd433, 10'd439, 10'd443, 10'd449, 10'd457, 10'd461, 10'd463, 10'd467, 10'd479,
         10'd487, 10'd491, 10'd499, 10'd503, 10'd509, 10'd521, 10'd523, 10'd541, 10'd547,
         10'd557, 10'd563, 10'd569, 10'd571, 10'd577, 10'd587, 10'd593, 10'd599, 10'd601,
         10'd607, 10'd613, 10'd617, 10'd619, 10'd631, 10'd641, 10'd643, 10'd647, 10'd653,
         10'd659, 10'd661, 10'd673, 10'd677, 10'd683, 10'd691, 10'd701, 10'd709, 10'd719
      };
      return t[i];
   endfunction

   function automatic logic [63:0] psq_value(input logic [IdxW-1:0] i);
      logic [63:0] t [0:PsqCount-1];
      t = '{
         64'd17, 64'd73, 64'd241, 64'd1009, 64'd2641, 64'd8089, 64'd18001, 64'd53881,
         64'd87481, 64'd117049, 64'd515761, 64'd1083289, 64'd3206641, 64'd3818929,
         64'd9257329, 64'd22000801, 64'd48473881, 64'd48473881, 64'd175244281,
         64'd427733329, 64'd427733329, 64'd898716289, 64'd2805544681,
         64'd2805544681, 64'd2805544681, 64'd10310263441, 64'd23616331489,
         64'd85157610409, 64'd85157610409, 64'd196265095009, 64'd196265095009,
         64'd2871842842801, 64'd2871842842801, 64'd2871842842801,
         64'd26250887023729, 64'd26250887023729, 64'd112434732901969,
         64'd112434732901969, 64'd112434732901969, 64'd178936222537081,
         64'd178936222537081, 64'd696161110209049, 64'd696161110209049,
         64'd2854909648103881, 64'd6450045516630769, 64'd6450045516630769,
         64'd11641399247947921, 64'd11641399247947921, 64'd190621428905186449,
         64'd196640148121928601, 64'd712624335095093521, 64'd1773855791877850321,
         64'd2327687064124474441, 64'd6384991873059836689, 64'd8019204661305419761,
         64'd10198100582046287689, 64'd10198100582046287689,
         64'd10198100582046287689
      };
      if (32'(i) >= PsqCount) begin
         return '1;
      end
      return t[i[PsqW-1:0]];
   endfunction
endpackage

// ----- design/pseudosquare_prime_test.sv -----
// Top level: pseudosquares primality test of one 64-bit candidate over one modular adder.
`timescale 1ns / 1ps
// One transaction in, one verdict out. A candidate runs one modular exponentiation per base
// on a single shared double-and-add modular adder that handles one multiplier bit per cycle.
// An exponentiation first reduces the base modulo n, then walks all 64 exponent bits (a squaring
// for each, plus a multiply per set bit), then checks the verdict. The bases tried are base 2,
// each prime up to the configured base prime, and for n = 1 mod 8 up to 57 more bases while
// the pseudosquare stays at most n.
// Zero, one, two and even candidates answer in the cycle after acceptance. req_stall is high
// while a test runs and while a finished verdict is held by rsp_stall.
module pseudosquare_prime_test (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_candidate,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_is_prime,
   input  logic        csr_write_enable,
   input  logic [8:0]  csr_write_data
);
   import psq_pkg::*;

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;
   logic [8:0] lbp_ff;
   logic [NumBits-1:0] n_ff, n_in, e_ff, e_in, b_ff, b_in, r_ff, r_in;
   logic [NumBits-1:0] acc_ff, acc_in, mop_ff, mop_in;
   logic [BitW-1:0] ebit_ff, ebit_in, mbit_ff, mbit_in;
   logic [IdxW-1:0] idx_ff, idx_in;
   logic rv_ff, rv_in, rp_ff, rp_in;

   logic [NumBits-1:0] minus1, dbl, sum, addend, step;
   logic [NumBits:0] dsum, ssum;
   logic cls1, cls5, res_one, res_m1, more_base, ext_ok, ext_go;
   logic [IdxW-1:0] idx_nx;
   logic [IdxW:0] ext_start;

   assign minus1 = n_ff - 1'b1;
   assign cls1 = (n_ff[2:0] == 3'd1);
   assign cls5 = (n_ff[2:0] == 3'd5);
   assign res_one = (r_ff == {{(NumBits-1){1'b0}}, 1'b1});
   assign res_m1 = (r_ff == minus1);
   assign addend = (state_ff == ST_REDUCE) ? NumBits'(1) : r_ff;

   // double then conditional add, each reduced by one compare-and-subtract
   assign dsum = {1'b0, acc_ff} + {1'b0, acc_ff};
   assign dbl = (dsum >= {1'b0, n_ff}) ? NumBits'(dsum - {1'b0, n_ff}) : dsum[NumBits-1:0];
   assign ssum = {1'b0, dbl} + {1'b0, addend};
   assign sum = (ssum >= {1'b0, n_ff}) ? NumBits'(ssum - {1'b0, n_ff}) : ssum[NumBits-1:0];
   assign step = mop_ff[mbit_ff] ? sum : dbl;

   assign idx_nx = idx_ff + 1'b1;
   assign more_base = (idx_ff != IdxW'(BaseTableDepth-1)) &&
      (base_prime(idx_nx) <= {1'b0, lbp_ff});
   assign ext_ok = (idx_ff != IdxW'(BaseTableDepth-1)) && (32'(idx_nx) < PsqCount) &&
      (psq_value(idx_nx) <= n_ff);
   // extension starts after the position of p
   assign ext_start = (lbp_ff < 9'd2) ? (IdxW+1)'(1) : ({1'b0, idx_ff} + (IdxW+1)'(2));
   assign ext_go = cls1 && (32'(ext_start) < PsqCount) &&
      (psq_value(ext_start[IdxW-1:0]) <= n_ff);

   assign req_stall = (state_ff != ST_IDLE) || (rv_ff && rsp_stall);
   assign rsp_valid = rv_ff;
   assign rsp_is_prime = rp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         lbp_ff <= 9'd271;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rv_ff <= rv_in;
         if (csr_write_enable) begin
            lbp_ff <= csr_write_data;
         end
      end
      phase_ff <= phase_in;
      n_ff <= n_in;
      e_ff <= e_in;
      b_ff <= b_in;
      r_ff <= r_in;
      acc_ff <= acc_in;
      mop_ff <= mop_in;
      ebit_ff <= ebit_in;
      mbit_ff <= mbit_in;
      idx_ff <= idx_in;
      rp_ff <= rp_in;
   end

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      n_in = n_ff;
      e_in = e_ff;
      b_in = b_ff;
      r_in = r_ff;
      acc_in = acc_ff;
      mop_in = mop_ff;
      ebit_in = ebit_ff;
      mbit_in = mbit_ff;
      idx_in = idx_ff;
      rv_in = rv_ff && rsp_stall;
      rp_in = rp_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && !req_stall) begin
               n_in = req_candidate[NumBits-1:0];
               e_in = req_candidate[NumBits-1:0] >> 1;
               idx_in = '0;
               phase_in = PH_BASE2;
               if (req_candidate[NumBits-1:0] == NumBits'(2)) begin
                  rv_in = 1'b1;
                  rp_in = 1'b1;
               end else if (req_candidate[NumBits-1:0] < NumBits'(3) || !req_candidate[0]) begin
                  rv_in = 1'b1;
                  rp_in = 1'b0;
               end else begin
                  state_in = ST_POW_START;
               end
            end
         end
         ST_POW_START: begin
            // reduce the base mod n as 1 * base
            acc_in = '0;
            mop_in = NumBits'(base_prime(idx_ff));
            mbit_in = BitW'(NumBits-1);
            r_in = NumBits'(1);
            ebit_in = BitW'(NumBits-1);
            state_in = ST_REDUCE;
         end
         ST_REDUCE: begin
            acc_in = step;
            mbit_in = mbit_ff - 1'b1;
            if (mbit_ff == '0) begin
               b_in = step;
               state_in = ST_SQ_START;
            end
         end
         ST_SQ_START: begin
            acc_in = '0;
            mop_in = r_ff;
            mbit_in = BitW'(NumBits-1);
            state_in = ST_SQ;
         end
         ST_SQ: begin
            acc_in = step;
            mbit_in = mbit_ff - 1'b1;
            if (mbit_ff == '0) begin
               r_in = step;
               state_in = e_ff[ebit_ff] ? ST_ML_START : ST_NEXT_BIT;
            end
         end
         ST_ML_START: begin
            acc_in = '0;
            mop_in = b_ff;
            mbit_in = BitW'(NumBits-1);
            state_in = ST_ML;
         end
         ST_ML: begin
            acc_in = step;
            mbit_in = mbit_ff - 1'b1;
            if (mbit_ff == '0) begin
               r_in = step;
               state_in = ST_NEXT_BIT;
            end
         end
         ST_NEXT_BIT: begin
            if (ebit_ff == '0) begin
               state_in = ST_CHECK;
            end else begin
               ebit_in = ebit_ff - 1'b1;
               state_in = ST_SQ_START;
            end
         end
         ST_CHECK: begin
            state_in = ST_POW_START;
            case (phase_ff)
               PH_BASE2, PH_BASES: begin
                  if (cls1 && res_m1) begin
                     rv_in = 1'b1;
                     rp_in = 1'b1;
                     state_in = ST_IDLE;
                  end else if ((phase_ff == PH_BASE2 && cls5 && !res_m1) ||
                        (!res_one && !res_m1)) begin
                     rv_in = 1'b1;
                     rp_in = 1'b0;
                     state_in = ST_IDLE;
                  end else if (more_base) begin
                     idx_in = idx_nx;
                     phase_in = PH_BASES;
                  end else if (ext_go) begin
                     idx_in = ext_start[IdxW-1:0];
                     phase_in = PH_EXT;
                  end else begin
                     rv_in = 1'b1;
                     rp_in = 1'b1;
                     state_in = ST_IDLE;
                  end
               end
               PH_EXT: begin
                  if (res_m1) begin
                     rv_in = 1'b1;
                     rp_in = 1'b1;
                     state_in = ST_IDLE;
                  end else if (!res_one) begin
                     rv_in = 1'b1;
                     rp_in = 1'b0;
                     state_in = ST_IDLE;
                  end else if (ext_ok) begin
                     idx_in = idx_nx;
                  end else begin
                     rv_in = 1'b1;
                     rp_in = 1'b1;
                     state_in = ST_IDLE;
                  end
               end
               default: begin
                  rv_in = 1'b1;
                  rp_in = 1'b0;
                  state_in = ST_IDLE;
               end
            endcase
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> req_stall)
      else $error("accepting while busy");
   assert property (@(posedge clock) disable iff (reset)
      (rv_ff && rsp_stall) |=> (rv_ff && $stable(rp_ff)))
      else $error("result dropped under stall");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SQ || state_ff == ST_ML || state_ff == ST_REDUCE) |->
         (acc_ff < n_ff && r_ff < n_ff))
      else $error("operand out of range");
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (rv_ff || state_ff == ST_POW_START))
      else $error("transaction lost");
endmodule
